// ===== design/assert_macros.svh =====
// assertion macros shared by the blob centroid design
// depends on a clock named clock and a reset named reset in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CBC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CBC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== design/cbc_pkg.sv =====
// shared constants, codes and types of the blob centroid design
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbc_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int PIX_W   = 8;
   localparam int FW_W    = 12;
   localparam int COORD_W = 11;
   localparam int CNT_W   = 22;
   localparam int SUM_W   = 33;
   localparam int CLS_W   = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   // divider step counter
   localparam int DSTEP_W = $clog2(SUM_W);

   // pixel class codes
   localparam logic [CLS_W-1:0] CLS_NONE  = 2'd0;
   localparam logic [CLS_W-1:0] CLS_BLUE  = 2'd1;
   localparam logic [CLS_W-1:0] CLS_GREEN = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_LEVEL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_LEVEL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_LEVEL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 2'd3;

   // one queued beat: recoloured pixel plus running totals, which are the frame totals on the last pixel
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [CLS_W-1:0] cls;
      logic             last;
      logic [CNT_W-1:0] b_cnt;
      logic [SUM_W-1:0] b_sx;
      logic [SUM_W-1:0] b_sy;
      logic [CNT_W-1:0] g_cnt;
      logic [SUM_W-1:0] g_sx;
      logic [SUM_W-1:0] g_sy;
   } entry_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [COORD_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== design/cbc_queue.sv =====
// short fifo of classified beats between front and back
// depends on cbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire cbc_pkg::entry_type push_data,
   input  wire logic               pop,
   output logic                    full,
   output logic                    empty,
   output cbc_pkg::entry_type      head
);
   import cbc_pkg::*;

   entry_type         slot_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;

   assign full  = (fill_ff == QCNT_W'(Q_DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/cbc_front.sv =====
// front end: config registers, pixel classification, raster position and per-colour totals
// depends on cbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbc_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   input  wire logic [cbc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cbc_pkg::FW_W-1:0]          csr_data,
   input  wire logic                              accept,
   input  wire logic [cbc_pkg::PIX_W-1:0]         pix_red,
   input  wire logic [cbc_pkg::PIX_W-1:0]         pix_green,
   input  wire logic [cbc_pkg::PIX_W-1:0]         pix_blue,
   input  wire logic                              end_of_frame,
   output cbc_pkg::entry_type                     push_data
);
   import cbc_pkg::*;

   logic [PIX_W-1:0]   blue_level_ff, red_level_ff, green_level_ff;
   logic [FW_W-1:0]    frame_width_ff;
   logic [COORD_W-1:0] column_ff, column_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0]   b_cnt_ff, g_cnt_ff;
   logic [SUM_W-1:0]   b_sx_ff, b_sy_ff, g_sx_ff, g_sy_ff;
   logic [FW_W-1:0]    width_eff;
   logic [FW_W-1:0]    column_next;
   logic               is_blue, is_green, add_blue, add_green;
   entry_type          entry;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         blue_level_ff  <= PIX_W'(130);
         red_level_ff   <= PIX_W'(120);
         green_level_ff <= PIX_W'(120);
         frame_width_ff <= FW_W'(640);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BLUE_LEVEL:  blue_level_ff  <= csr_data[PIX_W-1:0];
            CSR_RED_LEVEL:   red_level_ff   <= csr_data[PIX_W-1:0];
            CSR_GREEN_LEVEL: green_level_ff <= csr_data[PIX_W-1:0];
            CSR_FRAME_WIDTH: frame_width_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // classification, strict compares
   assign is_blue  = (pix_blue > blue_level_ff) && (pix_red < red_level_ff) &&
                     (pix_green < green_level_ff);
   assign is_green = (pix_blue < blue_level_ff) && (pix_red < red_level_ff) &&
                     (pix_green > green_level_ff);
   assign add_blue  = is_blue && (b_cnt_ff != COUNT_MAX);
   assign add_green = is_green && (g_cnt_ff != COUNT_MAX);

   // clamped row width and raster position
   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = FW_W'(1);
      end else if (frame_width_ff > FW_W'(MAX_WIDTH)) begin
         width_eff = FW_W'(MAX_WIDTH);
      end else begin
         width_eff = frame_width_ff;
      end
      column_next = {{(FW_W-COORD_W){1'b0}}, column_ff} + 1'b1;
      column_in   = column_ff;
      row_in      = row_ff;
      if (end_of_frame) begin
         column_in = '0;
         row_in    = '0;
      end else if (column_next >= width_eff) begin
         column_in = '0;
         if (row_ff != COORD_W'(MAX_HEIGHT - 1)) begin
            row_in = row_ff + 1'b1;
         end
      end else begin
         column_in = column_next[COORD_W-1:0];
      end
   end

   // beat to the queue, totals include this pixel
   always_comb begin
      entry.red   = pix_red;
      entry.green = pix_green;
      entry.blue  = pix_blue;
      entry.cls   = CLS_NONE;
      if (is_blue) begin
         entry.red   = '0;
         entry.green = '0;
         entry.blue  = '1;
         entry.cls   = CLS_BLUE;
      end else if (is_green) begin
         entry.red   = '0;
         entry.green = '1;
         entry.blue  = '0;
         entry.cls   = CLS_GREEN;
      end
      entry.last  = end_of_frame;
      entry.b_cnt = b_cnt_ff;
      entry.b_sx  = b_sx_ff;
      entry.b_sy  = b_sy_ff;
      entry.g_cnt = g_cnt_ff;
      entry.g_sx  = g_sx_ff;
      entry.g_sy  = g_sy_ff;
      if (add_blue) begin
         entry.b_cnt = b_cnt_ff + 1'b1;
         entry.b_sx  = b_sx_ff + SUM_W'(column_ff);
         entry.b_sy  = b_sy_ff + SUM_W'(row_ff);
      end
      if (add_green) begin
         entry.g_cnt = g_cnt_ff + 1'b1;
         entry.g_sx  = g_sx_ff + SUM_W'(column_ff);
         entry.g_sy  = g_sy_ff + SUM_W'(row_ff);
      end
   end

   assign push_data = entry;

   // accumulators, cleared after the last pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         b_cnt_ff  <= '0;
         b_sx_ff   <= '0;
         b_sy_ff   <= '0;
         g_cnt_ff  <= '0;
         g_sx_ff   <= '0;
         g_sy_ff   <= '0;
      end else if (accept) begin
         column_ff <= column_in;
         row_ff    <= row_in;
         if (end_of_frame) begin
            b_cnt_ff <= '0;
            b_sx_ff  <= '0;
            b_sy_ff  <= '0;
            g_cnt_ff <= '0;
            g_sx_ff  <= '0;
            g_sy_ff  <= '0;
         end else begin
            b_cnt_ff <= entry.b_cnt;
            b_sx_ff  <= entry.b_sx;
            b_sy_ff  <= entry.b_sy;
            g_cnt_ff <= entry.g_cnt;
            g_sx_ff  <= entry.g_sx;
            g_sy_ff  <= entry.g_sy;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/cbc_div.sv =====
// restoring divider, one quotient bit per cycle, low coordinate bits returned
// depends on cbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbc_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cbc_pkg::div_req_type req,
   output cbc_pkg::div_rsp_type      rsp
);
   import cbc_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DSTEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]   work_ff, work_in;
   logic [CNT_W-1:0]   divisor_ff, divisor_in;
   logic [CNT_W:0]     trial;
   logic [CNT_W+1:0]   diff;
   logic               fits;

   // one trial subtract per step
   assign trial = {rem_ff, work_ff[SUM_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, divisor_ff};
   assign fits  = !diff[CNT_W+1];

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      work_in    = work_ff;
      divisor_in = divisor_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         work_in    = req.dividend;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         work_in = {work_ff[SUM_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == DSTEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      work_ff    <= work_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = work_ff[COORD_W-1:0];

endmodule

`default_nettype wire

// ===== design/cbc_back.sv =====
// back end: centroid sequencing over the shared divider and the result register
// depends on cbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbc_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_empty,
   input  wire cbc_pkg::entry_type            q_head,
   output logic                               q_pop,
   output cbc_pkg::div_req_type               div_req,
   input  wire cbc_pkg::div_rsp_type          div_rsp,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [cbc_pkg::PIX_W-1:0]          rsp_out_red,
   output logic [cbc_pkg::PIX_W-1:0]          rsp_out_green,
   output logic [cbc_pkg::PIX_W-1:0]          rsp_out_blue,
   output logic [cbc_pkg::CLS_W-1:0]          rsp_pixel_class,
   output logic                               rsp_frame_done,
   output logic                               rsp_blue_found,
   output logic [cbc_pkg::COORD_W-1:0]        rsp_blue_x,
   output logic [cbc_pkg::COORD_W-1:0]        rsp_blue_y,
   output logic                               rsp_green_found,
   output logic [cbc_pkg::COORD_W-1:0]        rsp_green_x,
   output logic [cbc_pkg::COORD_W-1:0]        rsp_green_y
);
   import cbc_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_LOAD  = 2'd3;

   // quotient order: blue x, blue y, green x, green y
   localparam logic [1:0] QI_BLUE_X  = 2'd0;
   localparam logic [1:0] QI_BLUE_Y  = 2'd1;
   localparam logic [1:0] QI_GREEN_X = 2'd2;
   localparam logic [1:0] QI_GREEN_Y = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [1:0]         idx_ff, idx_in;
   logic [COORD_W-1:0] quot_ff [4];
   logic               valid_ff, valid_in;
   logic               out_free;
   logic               load_out;
   logic               b_found, g_found;

   assign out_free = !valid_ff || rsp_ready;
   assign b_found  = (q_head.b_cnt != '0);
   assign g_found  = (q_head.g_cnt != '0);

   // operand select for the divider
   always_comb begin
      div_req.start    = (state_ff == ST_START);
      div_req.dividend = q_head.b_sx;
      div_req.divisor  = q_head.b_cnt;
      case (idx_ff)
         QI_BLUE_X: begin
            div_req.dividend = q_head.b_sx;
            div_req.divisor  = q_head.b_cnt;
         end
         QI_BLUE_Y: begin
            div_req.dividend = q_head.b_sy;
            div_req.divisor  = q_head.b_cnt;
         end
         QI_GREEN_X: begin
            div_req.dividend = q_head.g_sx;
            div_req.divisor  = q_head.g_cnt;
         end
         QI_GREEN_Y: begin
            div_req.dividend = q_head.g_sy;
            div_req.divisor  = q_head.g_cnt;
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (q_head.last) begin
                  idx_in   = QI_BLUE_X;
                  state_in = ST_START;
               end else if (out_free) begin
                  load_out = 1'b1;
               end
            end
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               if (idx_ff == QI_GREEN_Y) begin
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_START;
               end
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      valid_in = valid_ff;
      if (load_out) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   assign q_pop = load_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= QI_BLUE_X;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // quotient capture
   always_ff @(posedge clock) begin
      if (state_ff == ST_WAIT && div_rsp.done) begin
         quot_ff[idx_ff] <= div_rsp.quotient;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_out_red     <= q_head.red;
         rsp_out_green   <= q_head.green;
         rsp_out_blue    <= q_head.blue;
         rsp_pixel_class <= q_head.cls;
         rsp_frame_done  <= q_head.last;
         rsp_blue_found  <= q_head.last && b_found;
         rsp_green_found <= q_head.last && g_found;
         rsp_blue_x      <= (q_head.last && b_found) ? quot_ff[QI_BLUE_X] : '0;
         rsp_blue_y      <= (q_head.last && b_found) ? quot_ff[QI_BLUE_Y] : '0;
         rsp_green_x     <= (q_head.last && g_found) ? quot_ff[QI_GREEN_X] : '0;
         rsp_green_y     <= (q_head.last && g_found) ? quot_ff[QI_GREEN_Y] : '0;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

// ===== design/color_blob_centroid_core.sv =====
// an ordinary pixel passes through the queue and the result register to rsp; throughput 1
// pixel/cycle unless rsp_ready is low or a frame's divisions hold the queue; last pixel of
// a frame: four serial divisions on one restoring divider; meanwhile the 4-deep queue takes
// up to three more pixels, then req_ready stays low until the frame result leaves the queue
// reset (synchronous): thresholds 130/120/120, width 640, position and totals cleared,
// queue and result register empty; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module color_blob_centroid_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [cbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cbc_pkg::FW_W-1:0]      csr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [cbc_pkg::PIX_W-1:0]     req_pix_red,
   input  wire logic [cbc_pkg::PIX_W-1:0]     req_pix_green,
   input  wire logic [cbc_pkg::PIX_W-1:0]     req_pix_blue,
   input  wire logic                          req_end_of_frame,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [cbc_pkg::PIX_W-1:0]          rsp_out_red,
   output logic [cbc_pkg::PIX_W-1:0]          rsp_out_green,
   output logic [cbc_pkg::PIX_W-1:0]          rsp_out_blue,
   output logic [cbc_pkg::CLS_W-1:0]          rsp_pixel_class,
   output logic                               rsp_frame_done,
   output logic                               rsp_blue_found,
   output logic [cbc_pkg::COORD_W-1:0]        rsp_blue_x,
   output logic [cbc_pkg::COORD_W-1:0]        rsp_blue_y,
   output logic                               rsp_green_found,
   output logic [cbc_pkg::COORD_W-1:0]        rsp_green_x,
   output logic [cbc_pkg::COORD_W-1:0]        rsp_green_y
);
   import cbc_pkg::*;

   logic        accept;
   logic        q_full, q_empty, q_pop;
   entry_type   push_data, q_head;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        mid_frame_beat, centroid_clear, blue_beat, blue_pure;

   // handshakes
   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   cbc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .accept       (accept),
      .pix_red      (req_pix_red),
      .pix_green    (req_pix_green),
      .pix_blue     (req_pix_blue),
      .end_of_frame (req_end_of_frame),
      .push_data    (push_data)
   );

   cbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (push_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   cbc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   cbc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .div_req         (div_req),
      .div_rsp         (div_rsp),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_pixel_class (rsp_pixel_class),
      .rsp_frame_done  (rsp_frame_done),
      .rsp_blue_found  (rsp_blue_found),
      .rsp_blue_x      (rsp_blue_x),
      .rsp_blue_y      (rsp_blue_y),
      .rsp_green_found (rsp_green_found),
      .rsp_green_x     (rsp_green_x),
      .rsp_green_y     (rsp_green_y)
   );

   // checks
   assign mid_frame_beat = rsp_valid && !rsp_frame_done;
   assign centroid_clear = !rsp_blue_found && !rsp_green_found &&
                           (rsp_blue_x == '0) && (rsp_blue_y == '0) &&
                           (rsp_green_x == '0) && (rsp_green_y == '0);
   assign blue_beat      = rsp_valid && (rsp_pixel_class == CLS_BLUE);
   assign blue_pure      = (rsp_out_red == '0) && (rsp_out_green == '0) && (rsp_out_blue == '1);

   `CBC_ASSERT_IMP(a_div_only_on_last, div_req.start, !q_empty && q_head.last, "stray divider start")
   `CBC_ASSERT_IMP(a_quiet_mid_frame, mid_frame_beat, centroid_clear, "centroid set mid-frame")
   `CBC_ASSERT_IMP(a_blue_recolour, blue_beat, blue_pure, "blue class pixel not pure blue")
   `CBC_ASSERT(a_no_pop_empty, !(q_pop && q_empty), "queue popped while empty")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking bench for the colour blob centroid core: random pixel streams, frames and
// threshold settings with its own centroid predictor; needs cbc_pkg and the core's rtl
`timescale 1ns / 1ps

module tb;
   import cbc_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             eof;
   } pixel_item_t;

   typedef struct packed {
      logic [PIX_W-1:0]   red;
      logic [PIX_W-1:0]   green;
      logic [PIX_W-1:0]   blue;
      logic [CLS_W-1:0]   cls;
      logic               done;
      logic               b_found;
      logic [COORD_W-1:0] b_x;
      logic [COORD_W-1:0] b_y;
      logic               g_found;
      logic [COORD_W-1:0] g_x;
      logic [COORD_W-1:0] g_y;
   } pixel_result_t;

   typedef enum int {PK_BLUE, PK_GREEN, PK_EDGE, PK_ANY} pixel_kind_t;

   logic clock;
   logic reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FW_W-1:0]      csr_data;
   logic                 req_valid;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pix_red;
   logic [PIX_W-1:0]     req_pix_green;
   logic [PIX_W-1:0]     req_pix_blue;
   logic                 req_end_of_frame;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [PIX_W-1:0]     rsp_out_red;
   logic [PIX_W-1:0]     rsp_out_green;
   logic [PIX_W-1:0]     rsp_out_blue;
   logic [CLS_W-1:0]     rsp_pixel_class;
   logic                 rsp_frame_done;
   logic                 rsp_blue_found;
   logic [COORD_W-1:0]   rsp_blue_x;
   logic [COORD_W-1:0]   rsp_blue_y;
   logic                 rsp_green_found;
   logic [COORD_W-1:0]   rsp_green_x;
   logic [COORD_W-1:0]   rsp_green_y;

   color_blob_centroid_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pix_red      (req_pix_red),
      .req_pix_green    (req_pix_green),
      .req_pix_blue     (req_pix_blue),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_pixel_class  (rsp_pixel_class),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_blue_found   (rsp_blue_found),
      .rsp_blue_x       (rsp_blue_x),
      .rsp_blue_y       (rsp_blue_y),
      .rsp_green_found  (rsp_green_found),
      .rsp_green_x      (rsp_green_x),
      .rsp_green_y      (rsp_green_y)
   );

   // pixels waiting for the driver and results still owed by the core
   pixel_item_t   pixels_to_send [$];
   pixel_result_t expected_pixels [$];
   int n_sent = 0;
   int n_accepted = 0;
   int mismatches = 0;
   int cycles = 0;
   bit req_taken = 0;

   // predictor copy of the registers, raster position and blob totals
   logic [PIX_W-1:0]   lvl_blue  = 8'd130;
   logic [PIX_W-1:0]   lvl_red   = 8'd120;
   logic [PIX_W-1:0]   lvl_green = 8'd120;
   logic [FW_W-1:0]    width_reg = 12'd640;
   logic [COORD_W-1:0] pos_col = '0;
   logic [COORD_W-1:0] pos_row = '0;
   logic [CNT_W-1:0]   blue_n = '0;
   logic [SUM_W-1:0]   blue_sx = '0;
   logic [SUM_W-1:0]   blue_sy = '0;
   logic [CNT_W-1:0]   green_n = '0;
   logic [SUM_W-1:0]   green_sx = '0;
   logic [SUM_W-1:0]   green_sy = '0;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap(input bit calm);
      int roll;
      roll = $urandom_range(99, 0);
      if (calm || roll < 65)
         return 0;
      else if (roll < 92)
         return $urandom_range(3, 1);
      else
         return $urandom_range(40, 8);
   endfunction

   function automatic logic [COORD_W-1:0] mean_coord(input logic [SUM_W-1:0] sum,
                                                      input logic [CNT_W-1:0] cnt);
      logic [SUM_W-1:0] quo;
      if (cnt == '0)
         return '0;
      quo = sum / {{(SUM_W-CNT_W){1'b0}}, cnt};
      return quo[COORD_W-1:0];
   endfunction

   // one blob pixel, unless the count is already full
   task automatic add_to_blob(inout logic [CNT_W-1:0] cnt, inout logic [SUM_W-1:0] sx,
                              inout logic [SUM_W-1:0] sy);
      if (cnt != COUNT_MAX) begin
         cnt = cnt + 1'b1;
         sx = sx + SUM_W'(pos_col);
         sy = sy + SUM_W'(pos_row);
      end
   endtask

   function automatic string fmt_result(input pixel_result_t res);
      return $sformatf("rgb %0d,%0d,%0d cls %0d done %0d blue %0d (%0d,%0d) green %0d (%0d,%0d)",
                       res.red, res.green, res.blue, res.cls, res.done, res.b_found,
                       res.b_x, res.b_y, res.g_found, res.g_x, res.g_y);
   endfunction

   // pixel aimed at one class under the current thresholds, at a threshold edge, or fully random
   function automatic pixel_item_t make_pixel(input pixel_kind_t kind, input bit eof);
      pixel_item_t px;
      bit as_blue;
      px.red = PIX_W'($urandom);
      px.green = PIX_W'($urandom);
      px.blue = PIX_W'($urandom);
      px.eof = eof;
      as_blue = (kind == PK_BLUE) || (kind == PK_EDGE && $urandom_range(1, 0) == 1);
      if (kind != PK_ANY) begin
         if (lvl_red > 0)
            px.red = PIX_W'($urandom_range(lvl_red - 1, 0));
         if (as_blue) begin
            if (lvl_blue < 255)
               px.blue = PIX_W'($urandom_range(255, lvl_blue + 1));
            if (lvl_green > 0)
               px.green = PIX_W'($urandom_range(lvl_green - 1, 0));
         end else begin
            if (lvl_blue > 0)
               px.blue = PIX_W'($urandom_range(lvl_blue - 1, 0));
            if (lvl_green < 255)
               px.green = PIX_W'($urandom_range(255, lvl_green + 1));
         end
      end
      if (kind == PK_EDGE) begin
         case ($urandom_range(2, 0))
            0: px.red = lvl_red;
            1: px.green = lvl_green;
            default: px.blue = lvl_blue;
         endcase
      end
      return px;
   endfunction

   function automatic logic [PIX_W-1:0] pick_level();
      case ($urandom_range(9, 0))
         0: return 8'd0;
         1: return 8'd255;
         2, 3: return PIX_W'($urandom);
         default: return PIX_W'($urandom_range(200, 60));
      endcase
   endfunction

   function automatic logic [FW_W-1:0] pick_width();
      case ($urandom_range(19, 0))
         0: return 12'd0;
         1: return 12'd2048;
         2: return 12'd4095;
         3: return FW_W'($urandom_range(4095, 2049));
         4: return 12'd640;
         5, 6: return FW_W'($urandom_range(2047, 1));
         default: return FW_W'($urandom_range(10, 1));
      endcase
   endfunction

   task automatic send_pixel(input pixel_item_t px);
      pixels_to_send.push_back(px);
      n_sent++;
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [FW_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // selected registers, levels with junk in the unused upper bits
   task automatic write_config(input logic [PIX_W-1:0] blue_lv, input logic [PIX_W-1:0] red_lv,
                               input logic [PIX_W-1:0] green_lv, input logic [FW_W-1:0] width,
                               input logic [3:0] sel);
      logic [FW_W-PIX_W-1:0] junk;
      junk = (FW_W-PIX_W)'($urandom);
      if (sel[CSR_BLUE_LEVEL])
         put_reg(CSR_BLUE_LEVEL, {junk, blue_lv});
      if (sel[CSR_RED_LEVEL])
         put_reg(CSR_RED_LEVEL, {~junk, red_lv});
      if (sel[CSR_GREEN_LEVEL])
         put_reg(CSR_GREEN_LEVEL, {junk, green_lv});
      if (sel[CSR_FRAME_WIDTH])
         put_reg(CSR_FRAME_WIDTH, width);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // all sent pixels accepted and all their results back
   task automatic wait_idle();
      do @(negedge clock); while (n_accepted != n_sent || expected_pixels.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // pixel driver, fed from the pending queue
   always @(negedge clock) begin : drive_pixels
      pixel_item_t px;
      int send_gap;
      int send_calm;
      if (reset) begin
         req_valid        <= 1'b0;
         req_pix_red      <= '0;
         req_pix_green    <= '0;
         req_pix_blue     <= '0;
         req_end_of_frame <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pixels_to_send.size() > 0) begin
            px = pixels_to_send.pop_front();
            req_pix_red      <= px.red;
            req_pix_green    <= px.green;
            req_pix_blue     <= px.blue;
            req_end_of_frame <= px.eof;
            req_valid        <= 1'b1;
            if (send_calm > 0)
               send_calm--;
            else if ($urandom_range(49, 0) == 0)
               send_calm = $urandom_range(80, 20);
            send_gap = pick_gap(send_calm > 0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin : drive_rsp_ready
      int rsp_stall;
      int rsp_calm;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_calm > 0)
            rsp_calm--;
         else if ($urandom_range(199, 0) == 0)
            rsp_calm = $urandom_range(150, 40);
         else if ($urandom_range(5, 0) == 0)
            rsp_stall = pick_gap(1'b0);
      end
   end

   // predictor and result checker, sampled at the rising edge
   always @(posedge clock) begin : predict_and_check
      pixel_result_t want;
      pixel_result_t got;
      int eff_w;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb NOT OK");
         $finish;
      end else begin
         req_taken = 1'b0;
         if (!reset) begin
            // register beat
            if (csr_valid && csr_ready) begin
               case (csr_index)
                  CSR_BLUE_LEVEL:  lvl_blue  = csr_data[PIX_W-1:0];
                  CSR_RED_LEVEL:   lvl_red   = csr_data[PIX_W-1:0];
                  CSR_GREEN_LEVEL: lvl_green = csr_data[PIX_W-1:0];
                  CSR_FRAME_WIDTH: width_reg = csr_data;
                  default: ;
               endcase
            end

            // pixel beat: classify, accumulate, report on the last pixel
            if (req_valid && req_ready) begin
               req_taken = 1'b1;
               n_accepted++;
               eff_w = width_reg;
               if (eff_w < 1)
                  eff_w = 1;
               if (eff_w > MAX_WIDTH)
                  eff_w = MAX_WIDTH;
               want = '0;
               want.red = req_pix_red;
               want.green = req_pix_green;
               want.blue = req_pix_blue;
               want.cls = CLS_NONE;
               if (req_pix_blue > lvl_blue && req_pix_red < lvl_red
                   && req_pix_green < lvl_green) begin
                  want.cls = CLS_BLUE;
                  want.red = 8'd0;
                  want.green = 8'd0;
                  want.blue = 8'd255;
                  add_to_blob(blue_n, blue_sx, blue_sy);
               end else if (req_pix_blue < lvl_blue && req_pix_red < lvl_red
                            && req_pix_green > lvl_green) begin
                  want.cls = CLS_GREEN;
                  want.red = 8'd0;
                  want.green = 8'd255;
                  want.blue = 8'd0;
                  add_to_blob(green_n, green_sx, green_sy);
               end
               want.done = req_end_of_frame;
               if (req_end_of_frame) begin
                  want.b_found = (blue_n != '0);
                  want.b_x = mean_coord(blue_sx, blue_n);
                  want.b_y = mean_coord(blue_sy, blue_n);
                  want.g_found = (green_n != '0);
                  want.g_x = mean_coord(green_sx, green_n);
                  want.g_y = mean_coord(green_sy, green_n);
                  blue_n = '0;
                  blue_sx = '0;
                  blue_sy = '0;
                  green_n = '0;
                  green_sx = '0;
                  green_sy = '0;
                  pos_col = '0;
                  pos_row = '0;
               end else if (int'(pos_col) + 1 >= eff_w) begin
                  pos_col = '0;
                  if (int'(pos_row) + 1 < MAX_HEIGHT)
                     pos_row = pos_row + 1'b1;
               end else begin
                  pos_col = pos_col + 1'b1;
               end
               expected_pixels.push_back(want);
            end

            // result beat against the oldest expectation
            if (rsp_valid && rsp_ready) begin
               got.red = rsp_out_red;
               got.green = rsp_out_green;
               got.blue = rsp_out_blue;
               got.cls = rsp_pixel_class;
               got.done = rsp_frame_done;
               got.b_found = rsp_blue_found;
               got.b_x = rsp_blue_x;
               got.b_y = rsp_blue_y;
               got.g_found = rsp_green_found;
               got.g_x = rsp_green_x;
               got.g_y = rsp_green_y;
               if (expected_pixels.size() == 0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("unexpected result beat: %s", fmt_result(got));
               end else begin
                  want = expected_pixels.pop_front();
                  if (got !== want) begin
                     mismatches++;
                     if (mismatches <= 10) begin
                        $display("result mismatch at cycle %0d", cycles);
                        $display("  expected %s", fmt_result(want));
                        $display("  actual   %s", fmt_result(got));
                     end
                  end
               end
            end
         end
      end
   end

   // stimulus sequence
   initial begin : stimulus
      int n_items;
      logic [3:0] sel;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset thresholds: pure colours, just inside and exactly on each level
      send_pixel('{8'd0, 8'd0, 8'd255, 1'b0});
      send_pixel('{8'd0, 8'd255, 8'd0, 1'b0});
      send_pixel('{8'd119, 8'd119, 8'd131, 1'b0});
      send_pixel('{8'd120, 8'd0, 8'd255, 1'b0});
      send_pixel('{8'd0, 8'd120, 8'd255, 1'b0});
      send_pixel('{8'd0, 8'd0, 8'd130, 1'b0});
      send_pixel('{8'd0, 8'd121, 8'd129, 1'b0});
      send_pixel('{8'd0, 8'd120, 8'd0, 1'b0});
      send_pixel('{8'd255, 8'd255, 8'd255, 1'b0});
      send_pixel('{8'd0, 8'd0, 8'd0, 1'b1});
      // frame with no colour at all, then a single-pixel frame
      send_pixel('{8'd0, 8'd0, 8'd0, 1'b1});
      send_pixel('{8'd200, 8'd100, 8'd50, 1'b1});
      wait_idle();

      // extreme levels, zero width acting as one
      write_config(8'd255, 8'd255, 8'd0, 12'd0, 4'b1111);
      send_pixel('{8'd254, 8'd1, 8'd254, 1'b0});
      send_pixel('{8'd0, 8'd0, 8'd255, 1'b0});
      send_pixel('{8'd254, 8'd0, 8'd0, 1'b0});
      send_pixel('{8'd0, 8'd255, 8'd0, 1'b1});
      wait_idle();

      // nothing can be classed, width beyond the maximum
      write_config(8'd0, 8'd0, 8'd255, 12'd4095, 4'b1111);
      send_pixel('{8'd0, 8'd0, 8'd0, 1'b0});
      send_pixel('{8'd0, 8'd255, 8'd255, 1'b0});
      send_pixel('{8'd255, 8'd255, 8'd255, 1'b1});
      wait_idle();

      // random phases; frames run across register changes, so width moves mid-row
      for (int ph = 0; ph < 12; ph++) begin
         sel = (ph == 0) ? 4'b1111 : 4'($urandom);
         write_config(pick_level(), pick_level(), pick_level(), pick_width(), sel);
         n_items = $urandom_range(65, 35);
         repeat (n_items) begin
            case ($urandom_range(19, 0))
               0, 1, 2, 3, 4, 5: send_pixel(make_pixel(PK_BLUE, $urandom_range(9, 0) == 0));
               6, 7, 8, 9, 10, 11: send_pixel(make_pixel(PK_GREEN, $urandom_range(9, 0) == 0));
               12, 13, 14: send_pixel(make_pixel(PK_EDGE, $urandom_range(9, 0) == 0));
               default: send_pixel(make_pixel(PK_ANY, $urandom_range(9, 0) == 0));
            endcase
         end
         wait_idle();
      end

      // drain, then allow for a last-pixel division still in flight
      repeat (300) @(negedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
